// ----- rtl/crbf_pkg.sv -----
// shared types and constants for the cigar region breakpoint finder
package crbf_pkg;

  // fixed field widths
  localparam int QW = 28;        // query positions, operation and read lengths
  localparam int CW_REG = 31;    // region coordinates and align start

  // stream payload widths; the tdata widths are padded to whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'd1;

  typedef enum logic [3:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } cigar_op_e;

  typedef enum logic [1:0] {
    ST_NO_OVERLAP  = 2'd0,
    ST_SUBSEQ      = 2'd1,
    ST_UNUSABLE    = 2'd2,
    ST_INCONSISTENT = 2'd3
  } result_status_e;

endpackage

// ----- rtl/cigar_region_breakpoint_finder.sv -----
// cigar region breakpoint finder: per-read cigar walk and region sub-interval result
//
// Usage: the CIGAR operations of a read arrive one per transfer on the s_axis
// channel; the first one (first_op in tuser) also carries align_start and
// read_length and clears the per-read state, the one with tlast set closes the
// read. Each closing operation produces exactly one result transfer on m_axis:
// status in tuser, spanning flags and query offsets in tdata. Operations that do
// not close a read produce nothing.
// region_start and region_end are written through the cfg channel (always ready);
// the user must write them only while no read is in flight; the block does not enforce it.
// Throughput: one operation per cycle while the result stages have room for a
// closing operation, set by the single registered step that walks the cursors
// and updates the leftmost, rightmost, start and end points. A closing operation
// passes the input register, finished-read snapshot and output register to m_axis.
// A stalled receiver holds the result; the snapshot stage and the input
// register keep accepting until all three stages are full, then
// s_axis_tready_o drops, only while a closing operation waits behind them.
// Reset empties all stages, clears the per-read state and sets both region
// registers to zero.
module cigar_region_breakpoint_finder #(
  parameter int REF_COORD_BITS = 32,
  parameter int OP_INDEX_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // s_axis_tdata_i: op_length[27:0], align_start[58:28], read_length[86:59], zero pad
  input  logic [crbf_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // s_axis_tuser_i: op_code[3:0], first_op[4]
  input  logic [crbf_pkg::IN_USER_W-1:0]       s_axis_tuser_i,
  input  logic                                 s_axis_tlast_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // m_axis_tdata_o: span_left[0], span_right[1], sub_start[30:2], sub_end[59:31],
  // core_start[88:60], core_end[118:89], zero pad
  output logic [crbf_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // m_axis_tuser_o: status[1:0]
  output logic [crbf_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [crbf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [crbf_pkg::CW_REG-1:0]          cfg_data_i
);
  import crbf_pkg::*;

  localparam int RB = REF_COORD_BITS;
  localparam int OB = OP_INDEX_BITS;
  // compare width that holds any reference coordinate or region bound plus a carry
  localparam int CW = ((RB > CW_REG) ? RB : CW_REG) + 2;
  localparam logic [CW-1:0] RMAX_W = CW'({RB{1'b1}});
  // signed width for the result arithmetic
  localparam int SW = QW + 3;
  localparam logic signed [SW-1:0] NEG1 = '1;

  typedef struct packed {
    logic          aligned;
    logic [RB-1:0] left_ref;
    logic [RB-1:0] right_ref;
    logic          sp_valid;
    logic [QW-1:0] sp_qry;
    logic          sp_op1;
    logic          ep_valid;
    logic [QW-1:0] ep_qry;
    logic          lclip;
    logic [QW-1:0] lclip_len;
    logic [QW-1:0] rd_len;
  } snap_t;

  // configuration
  logic [CW_REG-1:0] region_start_q, region_end_q;
  logic [CW-1:0]     rs_w, re_w;

  // input register
  logic              s1_valid_q;
  logic [3:0]        s1_op_q;
  logic [QW-1:0]     s1_len_q;
  logic              s1_first_q, s1_last_q;
  logic [CW_REG-1:0] s1_as_q;
  logic [QW-1:0]     s1_rl_q;

  // per-read state
  logic [RB-1:0]     ref_cur_q, ref_cur_d;
  logic [QW-1:0]     qry_cur_q, qry_cur_d;
  logic [OB-1:0]     op_cnt_q, op_cnt_d;
  logic [QW-1:0]     rd_len_q, rd_len_d;
  logic              aligned_q, aligned_d;
  logic [RB-1:0]     left_ref_q, left_ref_d;
  logic [RB-1:0]     right_ref_q, right_ref_d;
  logic              sp_valid_q, sp_valid_d;
  logic [RB-1:0]     sp_dist_q, sp_dist_d;
  logic [QW-1:0]     sp_qry_q, sp_qry_d;
  logic              sp_op1_q, sp_op1_d;
  logic              ep_valid_q, ep_valid_d;
  logic [CW_REG-1:0] ep_dist_q, ep_dist_d;
  logic [QW-1:0]     ep_qry_q, ep_qry_d;
  logic              lclip_q, lclip_d;
  logic [QW-1:0]     lclip_len_q, lclip_len_d;

  // state after the first-op clear
  logic [RB-1:0]     b_ref;
  logic [QW-1:0]     b_qry;
  logic [OB-1:0]     b_cnt;
  logic              b_aligned, b_sp_valid, b_ep_valid;
  logic [RB-1:0]     b_right_ref, b_sp_dist;
  logic [CW_REG-1:0] b_ep_dist;
  logic [CW-1:0]     as_w;

  // match step
  logic [QW-1:0]     jr, jr_eff, sp_j, ep_j;
  logic [CW-1:0]     r0_w, rj_w, rlast_w, ep_span, r_sum;
  logic              r_over;
  logic [RB-1:0]     rlast, r_add, sp_d;
  logic [CW_REG-1:0] ep_d;
  logic              sp_hit, sp_better, ep_hit, ep_better, right_better;

  // pipeline control
  logic  s_accept, s1_adv, st2_valid_q, st2_adv, st2_free, st3_ready;
  snap_t snap_d, snap_q;

  // result stage
  logic [CW-1:0]          lref_w, rref_w;
  logic signed [SW-1:0]   qs, qe, qs_adj, ss, se, cs, ce, rl, span_len;
  logic                   sl, sr;
  result_status_e         st;

  logic                   out_valid_q;
  result_status_e         out_status_q;
  logic                   out_span_l_q, out_span_r_q;
  logic [QW:0]            out_sub_s_q, out_sub_e_q, out_core_s_q;
  logic [QW+1:0]          out_core_e_q;

  function automatic logic [QW-1:0] qsat(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[QW] ? {QW{1'b1}} : s[QW-1:0];
  endfunction

  // configuration channel
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_REGION_START: region_start_q <= cfg_data_i;
        CFG_REGION_END:   region_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rs_w = CW'(region_start_q);
  assign re_w = CW'(region_end_q);

  // handshakes
  assign st3_ready       = !out_valid_q || m_axis_tready_i;
  assign st2_adv         = st2_valid_q && st3_ready;
  assign st2_free        = !st2_valid_q || st3_ready;
  assign s1_adv          = s1_valid_q && (!s1_last_q || st2_free);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_op_q    <= s_axis_tuser_i[3:0];
      s1_first_q <= s_axis_tuser_i[4];
      s1_last_q  <= s_axis_tlast_i;
      s1_len_q   <= s_axis_tdata_i[27:0];
      s1_as_q    <= s_axis_tdata_i[58:28];
      s1_rl_q    <= s_axis_tdata_i[86:59];
    end
  end

  // first op clears the read before the op itself is taken
  always_comb begin
    as_w        = CW'(s1_as_q);
    b_ref       = s1_first_q ? ((as_w > RMAX_W) ? RMAX_W[RB-1:0] : as_w[RB-1:0]) : ref_cur_q;
    b_qry       = s1_first_q ? '0 : qry_cur_q;
    b_cnt       = s1_first_q ? '0 : op_cnt_q;
    b_aligned   = s1_first_q ? 1'b0 : aligned_q;
    b_right_ref = s1_first_q ? '0 : right_ref_q;
    b_sp_valid  = s1_first_q ? 1'b0 : sp_valid_q;
    b_sp_dist   = s1_first_q ? '0 : sp_dist_q;
    b_ep_valid  = s1_first_q ? 1'b0 : ep_valid_q;
    b_ep_dist   = s1_first_q ? '0 : ep_dist_q;
  end

  // closed form for one match run
  always_comb begin
    jr      = s1_len_q - 1'b1;
    r0_w    = CW'(b_ref);
    rj_w    = r0_w + CW'(jr);
    r_over  = rj_w > RMAX_W;
    rlast   = r_over ? RMAX_W[RB-1:0] : rj_w[RB-1:0];
    jr_eff  = r_over ? QW'(RMAX_W - r0_w) : jr;
    rlast_w = CW'(rlast);
    right_better = !b_aligned || (rlast > b_right_ref);

    sp_hit    = rlast_w >= rs_w;
    sp_j      = (rs_w > r0_w) ? QW'(rs_w - r0_w) : '0;
    sp_d      = (r0_w > rs_w) ? RB'(r0_w - rs_w) : '0;
    sp_better = !b_sp_valid || (sp_d < b_sp_dist);

    ep_hit    = r0_w <= re_w;
    ep_span   = re_w - r0_w;
    ep_j      = (ep_span > CW'(jr_eff)) ? jr_eff : QW'(ep_span);
    ep_d      = CW_REG'(ep_span - CW'(ep_j));
    ep_better = !b_ep_valid || (ep_d < b_ep_dist);

    r_sum = r0_w + CW'(s1_len_q);
    r_add = (r_sum > RMAX_W) ? RMAX_W[RB-1:0] : r_sum[RB-1:0];
  end

  always_comb begin
    ref_cur_d   = b_ref;
    qry_cur_d   = b_qry;
    op_cnt_d    = (&b_cnt) ? b_cnt : b_cnt + 1'b1;
    rd_len_d    = s1_first_q ? s1_rl_q : rd_len_q;
    aligned_d   = b_aligned;
    left_ref_d  = s1_first_q ? '0 : left_ref_q;
    right_ref_d = b_right_ref;
    sp_valid_d  = b_sp_valid;
    sp_dist_d   = b_sp_dist;
    sp_qry_d    = s1_first_q ? '0 : sp_qry_q;
    sp_op1_d    = s1_first_q ? 1'b0 : sp_op1_q;
    ep_valid_d  = b_ep_valid;
    ep_dist_d   = b_ep_dist;
    ep_qry_d    = s1_first_q ? '0 : ep_qry_q;
    lclip_d     = s1_first_q ? 1'b0 : lclip_q;
    lclip_len_d = s1_first_q ? '0 : lclip_len_q;

    case (cigar_op_e'(s1_op_q))
      OP_S, OP_H: begin
        if (b_cnt == '0) begin
          lclip_d     = 1'b1;
          lclip_len_d = s1_len_q;
        end
        if (cigar_op_e'(s1_op_q) == OP_S) begin
          qry_cur_d = qsat(b_qry, s1_len_q);
        end
      end
      OP_M, OP_EQ, OP_X: begin
        if (s1_len_q != '0) begin
          if (!b_aligned) begin
            left_ref_d = b_ref;
          end
          aligned_d = 1'b1;
          if (right_better) begin
            right_ref_d = rlast;
          end
          if (sp_hit && sp_better) begin
            sp_valid_d = 1'b1;
            sp_dist_d  = sp_d;
            sp_qry_d   = qsat(b_qry, sp_j);
            sp_op1_d   = (b_cnt == OB'(1));
          end
          if (ep_hit && ep_better) begin
            ep_valid_d = 1'b1;
            ep_dist_d  = ep_d;
            ep_qry_d   = qsat(b_qry, ep_j);
          end
        end
        ref_cur_d = r_add;
        qry_cur_d = qsat(b_qry, s1_len_q);
      end
      OP_I: qry_cur_d = qsat(b_qry, s1_len_q);
      OP_D: ref_cur_d = r_add;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cur_q   <= '0;
      qry_cur_q   <= '0;
      op_cnt_q    <= '0;
      rd_len_q    <= '0;
      aligned_q   <= 1'b0;
      left_ref_q  <= '0;
      right_ref_q <= '0;
      sp_valid_q  <= 1'b0;
      sp_dist_q   <= '0;
      sp_qry_q    <= '0;
      sp_op1_q    <= 1'b0;
      ep_valid_q  <= 1'b0;
      ep_dist_q   <= '0;
      ep_qry_q    <= '0;
      lclip_q     <= 1'b0;
      lclip_len_q <= '0;
    end else if (s1_adv) begin
      ref_cur_q   <= ref_cur_d;
      qry_cur_q   <= qry_cur_d;
      op_cnt_q    <= op_cnt_d;
      rd_len_q    <= rd_len_d;
      aligned_q   <= aligned_d;
      left_ref_q  <= left_ref_d;
      right_ref_q <= right_ref_d;
      sp_valid_q  <= sp_valid_d;
      sp_dist_q   <= sp_dist_d;
      sp_qry_q    <= sp_qry_d;
      sp_op1_q    <= sp_op1_d;
      ep_valid_q  <= ep_valid_d;
      ep_dist_q   <= ep_dist_d;
      ep_qry_q    <= ep_qry_d;
      lclip_q     <= lclip_d;
      lclip_len_q <= lclip_len_d;
    end
  end

  // snapshot of the finished read
  always_comb begin
    snap_d.aligned   = aligned_d;
    snap_d.left_ref  = left_ref_d;
    snap_d.right_ref = right_ref_d;
    snap_d.sp_valid  = sp_valid_d;
    snap_d.sp_qry    = sp_qry_d;
    snap_d.sp_op1    = sp_op1_d;
    snap_d.ep_valid  = ep_valid_d;
    snap_d.ep_qry    = ep_qry_d;
    snap_d.lclip     = lclip_d;
    snap_d.lclip_len = lclip_len_d;
    snap_d.rd_len    = rd_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      st2_valid_q <= 1'b1;
    end else if (st2_adv) begin
      st2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      snap_q <= snap_d;
    end
  end

  // result from the snapshot
  always_comb begin
    lref_w   = CW'(snap_q.left_ref);
    rref_w   = CW'(snap_q.right_ref);
    qs       = snap_q.sp_valid ? $signed({3'b000, snap_q.sp_qry}) : NEG1;
    qe       = snap_q.ep_valid ? $signed({3'b000, snap_q.ep_qry}) : NEG1;
    rl       = $signed({3'b000, snap_q.rd_len});
    qs_adj   = qs;
    sl       = 1'b0;
    sr       = 1'b0;
    ss       = NEG1;
    se       = NEG1;
    cs       = NEG1;
    ce       = NEG1;
    span_len = '0;
    st       = ST_NO_OVERLAP;
    if (!snap_q.aligned || rref_w < rs_w || lref_w > re_w) begin
      st = ST_NO_OVERLAP;
    end else if (snap_q.sp_valid && snap_q.ep_valid && snap_q.sp_qry > snap_q.ep_qry) begin
      // region lies inside a deletion
      st = ST_UNUSABLE;
      sl = 1'b1;
      sr = 1'b1;
    end else begin
      // left clip widens the interval when the start point sits in the op after it
      if (lref_w > rs_w && snap_q.lclip && snap_q.sp_op1 && snap_q.sp_valid &&
          snap_q.sp_qry != '0) begin
        qs_adj = qs - $signed({3'b000, snap_q.lclip_len});
      end
      sl = lref_w <= rs_w;
      sr = rref_w >= re_w;
      if (sl && sr) begin
        ss = qs_adj;
        se = qe;
      end else if (sl) begin
        ss = qs_adj;
        se = rl;
      end else if (sr) begin
        ss = '0;
        se = qe;
      end else begin
        ss = '0;
        se = rl;
      end
      cs       = qs;
      ce       = qe;
      span_len = se - ss;
      if ((ss == NEG1) != (se == NEG1)) begin
        st = ST_INCONSISTENT;
      end else if (ss == NEG1 || rl < span_len) begin
        st = ST_UNUSABLE;
      end else begin
        st = ST_SUBSEQ;
        cs = qs - ss;
        ce = qe - ss;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st2_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st2_adv) begin
      out_status_q <= st;
      out_span_l_q <= sl;
      out_span_r_q <= sr;
      out_sub_s_q  <= ss[QW:0];
      out_sub_e_q  <= se[QW:0];
      out_core_s_q <= cs[QW:0];
      out_core_e_q <= ce[QW+1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_core_e_q, out_core_s_q, out_sub_e_q, out_sub_s_q,
                            out_span_r_q, out_span_l_q};

`ifndef SYNTH
  a_no_overlap_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_status_q == ST_NO_OVERLAP |->
      !out_span_l_q && !out_span_r_q && (&out_sub_s_q) && (&out_sub_e_q))
    else $error("no-overlap result carries spans or offsets");

  a_subseq_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_status_q == ST_SUBSEQ |-> !(&out_sub_s_q) && !(&out_sub_e_q))
    else $error("subsequence result without both bounds");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |->
      s1_valid_q && s1_last_q && st2_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled with room in the pipeline");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st2_valid_q && out_valid_q && !m_axis_tready_i |=> st2_valid_q)
    else $error("finished read lost while output stalled");
`endif

endmodule
